// ----- sv/fsne_pkg.sv -----
// Package for the FAT 8.3 short name encoder.
// Holds character constants, error codes, the per-component state type and its clear value.
// No dependencies.
package fsne_pkg;

   localparam logic [7:0]  SPACE_CHAR  = 8'h20;
   localparam logic [7:0]  DOT_CHAR    = 8'h2E;
   localparam logic [7:0]  SLASH_CHAR  = 8'h2F;
   localparam logic [7:0]  LOWER_A     = 8'h61;
   localparam logic [7:0]  LOWER_Z     = 8'h7A;
   localparam logic [7:0]  CASE_OFFSET = 8'h20;
   localparam logic [63:0] NAME_SPACES = 64'h2020202020202020;
   localparam logic [23:0] EXT_SPACES  = 24'h202020;
   localparam logic [3:0]  BASE_CHARS  = 4'd8;
   localparam logic [1:0]  EXT_LEN     = 2'd3;
   localparam logic [1:0]  LEN_SAT     = 2'd3;
   localparam logic [7:0]  COUNT_SAT   = 8'd255;

   localparam logic [1:0] ERR_OK        = 2'd0;
   localparam logic [1:0] ERR_EMPTY_EXT = 2'd1;
   localparam logic [1:0] ERR_MULTI_DOT = 2'd2;

   typedef struct packed {
      logic [63:0] name_buf;
      logic [23:0] ext_buf;
      logic [3:0]  name_cnt;
      logic [1:0]  ext_cnt;
      logic        dot_seen;
      logic        scan_stopped;
      logic [1:0]  pend_err;
      logic [1:0]  comp_len;
      logic        all_dots;
   } comp_type;

   localparam comp_type COMP_CLEAR = '{
      name_buf:     NAME_SPACES,
      ext_buf:      EXT_SPACES,
      name_cnt:     4'd0,
      ext_cnt:      2'd0,
      dot_seen:     1'b0,
      scan_stopped: 1'b0,
      pend_err:     ERR_OK,
      comp_len:     2'd0,
      all_dots:     1'b1
   };

endpackage

// ----- sv/fsne_absorb.sv -----
// Per-character update of the component state of the short name encoder.
// Pure combinational; depends on fsne_pkg.
module fsne_absorb
   import fsne_pkg::*;
(
   input  comp_type   cur,
   input  logic [7:0] ch,
   output comp_type   nxt
);

   logic [7:0] up;

   always_comb begin
      up  = ((ch >= LOWER_A) && (ch <= LOWER_Z)) ? (ch - CASE_OFFSET) : ch;
      nxt = cur;
      if (cur.comp_len < LEN_SAT) begin
         nxt.comp_len = cur.comp_len + 2'd1;
      end
      if (ch != DOT_CHAR) begin
         nxt.all_dots = 1'b0;
      end
      if (!cur.scan_stopped) begin
         if (ch == DOT_CHAR) begin
            if (cur.dot_seen) begin
               if (cur.pend_err == ERR_OK) begin
                  nxt.pend_err = ERR_MULTI_DOT;
               end
            end else begin
               nxt.dot_seen = 1'b1;
            end
         end else if (!cur.dot_seen) begin
            if (cur.name_cnt < BASE_CHARS) begin
               for (int i = 0; i < 8; i++) begin
                  if (cur.name_cnt == 4'(i)) begin
                     nxt.name_buf[(7 - i) * 8 +: 8] = up;
                  end
               end
               nxt.name_cnt = cur.name_cnt + 4'd1;
            end
         end else if (cur.ext_cnt == EXT_LEN) begin
            nxt.scan_stopped = 1'b1;
         end else begin
            for (int i = 0; i < 3; i++) begin
               if (cur.ext_cnt == 2'(i)) begin
                  nxt.ext_buf[(2 - i) * 8 +: 8] = up;
               end
            end
            nxt.ext_cnt = cur.ext_cnt + 2'd1;
         end
      end
   end

endmodule

// ----- sv/fat_short_name_encoder_top.sv -----
// Top level of the FAT 8.3 short name encoder: component state, result register, handshakes.
// Depends on fsne_pkg and fsne_absorb.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_ready  req_path_byte, req_end_of_path
//   rsp      out        rsp_valid/rsp_ready  rsp_base_name, rsp_extension,
//                                            rsp_component_index, rsp_last_component,
//                                            rsp_error_code
//
// One path byte is taken per cycle; its result, if any, shows on rsp the next cycle.
// The single result register sets the rate: a new byte is taken whenever it is empty
// or being drained in the same cycle.
// Synchronous reset clears component state and the result valid; no clearing pass.
// A stalled result holds req off until rsp_ready rises.
module fat_short_name_encoder_top
   import fsne_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_path_byte,
   input  logic        req_end_of_path,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_base_name,
   output logic [23:0] rsp_extension,
   output logic [7:0]  rsp_component_index,
   output logic        rsp_last_component,
   output logic [1:0]  rsp_error_code
);

   comp_type    comp_ff, comp_in, absorbed, cur_after;
   logic [7:0]  count_ff, count_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [63:0] base_ff, base_in;
   logic [23:0] ext_ff, ext_in;
   logic [7:0]  index_ff;
   logic        last_ff;
   logic [1:0]  err_ff, err_in;
   logic        accept, is_slash, ends, emit;

   fsne_absorb u_absorb (
      .cur (comp_ff),
      .ch  (req_path_byte),
      .nxt (absorbed)
   );

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   always_comb begin
      is_slash  = (req_path_byte == SLASH_CHAR);
      ends      = is_slash || req_end_of_path;
      cur_after = is_slash ? comp_ff : absorbed;
      emit      = ends && (cur_after.comp_len != 2'd0);

      base_in = cur_after.name_buf;
      ext_in  = cur_after.ext_buf;
      err_in  = cur_after.pend_err;
      priority if (cur_after.all_dots && (cur_after.comp_len == 2'd1)) begin
         base_in = {DOT_CHAR, NAME_SPACES[55:0]};
         ext_in  = EXT_SPACES;
         err_in  = ERR_OK;
      end else if (cur_after.all_dots && (cur_after.comp_len == 2'd2)) begin
         base_in = {DOT_CHAR, DOT_CHAR, NAME_SPACES[47:0]};
         ext_in  = EXT_SPACES;
         err_in  = ERR_OK;
      end else if ((cur_after.pend_err == ERR_OK) && cur_after.dot_seen &&
                   (cur_after.ext_cnt == 2'd0)) begin
         err_in = ERR_EMPTY_EXT;
      end else begin
         err_in = cur_after.pend_err;
      end

      comp_in  = comp_ff;
      count_in = count_ff;
      if (accept) begin
         comp_in = ends ? COMP_CLEAR : cur_after;
         if (req_end_of_path) begin
            count_in = 8'd0;
         end else if (emit && (count_ff != COUNT_SAT)) begin
            count_in = count_ff + 8'd1;
         end
      end

      if (accept && emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         comp_ff      <= COMP_CLEAR;
         count_ff     <= 8'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         comp_ff      <= comp_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && emit) begin
         base_ff  <= base_in;
         ext_ff   <= ext_in;
         index_ff <= count_ff;
         last_ff  <= req_end_of_path;
         err_ff   <= err_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_base_name       = base_ff;
   assign rsp_extension       = ext_ff;
   assign rsp_component_index = index_ff;
   assign rsp_last_component  = last_ff;
   assign rsp_error_code      = err_ff;

endmodule

// ----- sim/fat_short_name_encoder_top_tb.sv -----
// Self-checking testbench for fat_short_name_encoder_top: directed and random paths, random
// gaps and stalls on both channels, each short name checked against an in-bench predictor.
// Depends on fsne_pkg and the encoder RTL.
`timescale 1ns / 100ps

module fat_short_name_encoder_top_tb;
   import fsne_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_BYTES = 1450;

   typedef struct {
      logic [7:0] ch;
      logic       fin;
      bit         drain;
   } path_item_type;

   typedef struct {
      logic [63:0] base;
      logic [23:0] ext;
      logic [7:0]  idx;
      logic        last;
      logic [1:0]  err;
   } short_name_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_path_byte = 8'h00;
   logic        req_end_of_path = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [63:0] rsp_base_name;
   logic [23:0] rsp_extension;
   logic [7:0]  rsp_component_index;
   logic        rsp_last_component;
   logic [1:0]  rsp_error_code;

   path_item_type  path_bytes[$];
   logic [7:0]     path_buf[$];
   short_name_type names_due[$];

   comp_type    cur = COMP_CLEAR;
   logic [7:0]  comp_idx = 8'd0;

   int          mismatch_count = 0;
   int          cycle_count = 0;
   int          gap_left = 0;
   int          stall_left = 0;
   bit          tx_calm = 1'b0;
   bit          rx_calm = 1'b0;

   fat_short_name_encoder_top dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_path_byte       (req_path_byte),
      .req_end_of_path     (req_end_of_path),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_base_name       (rsp_base_name),
      .rsp_extension       (rsp_extension),
      .rsp_component_index (rsp_component_index),
      .rsp_last_component  (rsp_last_component),
      .rsp_error_code      (rsp_error_code)
   );

   always #5 clock = ~clock;

   // Predictor: fold one character into the current component.
   function automatic void take_char(logic [7:0] c);
      logic [7:0] u;
      if (cur.comp_len < LEN_SAT) cur.comp_len = cur.comp_len + 2'd1;
      if (c != DOT_CHAR) cur.all_dots = 1'b0;
      if (cur.scan_stopped) return;
      if (c == DOT_CHAR) begin
         if (cur.dot_seen) begin
            if (cur.pend_err == ERR_OK) cur.pend_err = ERR_MULTI_DOT;
         end else begin
            cur.dot_seen = 1'b1;
         end
         return;
      end
      u = (c >= LOWER_A && c <= LOWER_Z) ? c - CASE_OFFSET : c;
      if (!cur.dot_seen) begin
         if (cur.name_cnt < BASE_CHARS) begin
            cur.name_buf[63 - 8 * int'(cur.name_cnt) -: 8] = u;
            cur.name_cnt = cur.name_cnt + 4'd1;
         end
         return;
      end
      if (cur.ext_cnt >= EXT_LEN) begin
         cur.scan_stopped = 1'b1;
         return;
      end
      cur.ext_buf[23 - 8 * int'(cur.ext_cnt) -: 8] = u;
      cur.ext_cnt = cur.ext_cnt + 2'd1;
   endfunction

   function automatic void close_component(logic last);
      short_name_type r;
      r.base = cur.name_buf;
      r.ext  = cur.ext_buf;
      r.err  = cur.pend_err;
      if (cur.all_dots && cur.comp_len == 2'd1) begin
         r.base = {DOT_CHAR, NAME_SPACES[55:0]};
         r.ext  = EXT_SPACES;
         r.err  = ERR_OK;
      end else if (cur.all_dots && cur.comp_len == 2'd2) begin
         r.base = {DOT_CHAR, DOT_CHAR, NAME_SPACES[47:0]};
         r.ext  = EXT_SPACES;
         r.err  = ERR_OK;
      end else if (r.err == ERR_OK && cur.dot_seen && cur.ext_cnt == 2'd0) begin
         r.err = ERR_EMPTY_EXT;
      end
      r.idx  = comp_idx;
      r.last = last;
      names_due.push_back(r);
      if (comp_idx != COUNT_SAT) comp_idx = comp_idx + 8'd1;
   endfunction

   function automatic void encode_byte(logic [7:0] b, logic fin);
      if (b != SLASH_CHAR) take_char(b);
      if (b == SLASH_CHAR || fin) begin
         if (cur.comp_len != 2'd0) close_component(fin);
         cur = COMP_CLEAR;
         if (fin) comp_idx = 8'd0;
      end
   endfunction

   function automatic int pick_gap();
      if ($urandom_range(0, 99) < 80) return $urandom_range(1, 3);
      return $urandom_range(6, 30);
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      if (mismatch_count < 100)
         $display("mismatch %s: got %h, want %h (cycle %0d)", what, got, want, cycle_count);
      mismatch_count++;
   endtask

   // Stimulus building: characters go to path_buf, queue_path moves them out as one path.
   function automatic logic [7:0] rand_name_char();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) return 8'(8'h61 + $urandom_range(0, 25));
      if (r < 60) return 8'(8'h41 + $urandom_range(0, 25));
      if (r < 75) return 8'(8'h30 + $urandom_range(0, 9));
      if (r < 85) return 8'h5F;
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic add_text(string s);
      for (int i = 0; i < s.len(); i++) path_buf.push_back(s[i]);
   endtask

   task automatic add_chars(int n);
      repeat (n) path_buf.push_back(rand_name_char());
   endtask

   task automatic queue_path(bit drain);
      path_item_type it;
      for (int i = 0; i < path_buf.size(); i++) begin
         it.ch    = path_buf[i];
         it.fin   = (i == path_buf.size() - 1);
         it.drain = drain && (i == 0);
         path_bytes.push_back(it);
      end
      path_buf.delete();
   endtask

   task automatic add_component();
      int kind;
      kind = $urandom_range(0, 99);
      if (kind < 35) begin
         add_chars($urandom_range(1, 11));
      end else if (kind < 65) begin
         add_chars($urandom_range(0, 9));
         path_buf.push_back(DOT_CHAR);
         add_chars($urandom_range(0, 5));
      end else if (kind < 72) begin
         path_buf.push_back(DOT_CHAR);
      end else if (kind < 79) begin
         path_buf.push_back(DOT_CHAR);
         path_buf.push_back(DOT_CHAR);
      end else if (kind < 88) begin
         repeat ($urandom_range(2, 10))
            path_buf.push_back(($urandom_range(0, 2) == 0) ? DOT_CHAR : rand_name_char());
      end else if (kind < 93) begin
         repeat ($urandom_range(3, 5)) path_buf.push_back(DOT_CHAR);
      end else begin
         repeat ($urandom_range(1, 6)) path_buf.push_back(8'($urandom_range(0, 255)));
      end
   endtask

   task automatic add_random_path(bit drain);
      int parts;
      parts = $urandom_range(1, 5);
      if ($urandom_range(0, 9) < 3) path_buf.push_back(SLASH_CHAR);
      for (int i = 0; i < parts; i++) begin
         if (i > 0) begin
            repeat (($urandom_range(0, 4) == 0) ? $urandom_range(2, 3) : 1)
               path_buf.push_back(SLASH_CHAR);
         end
         add_component();
      end
      if ($urandom_range(0, 6) == 0) path_buf.push_back(SLASH_CHAR);
      queue_path(drain);
   endtask

   // Driver: present queued path bytes, predict on each accepted item.
   always @(posedge clock) begin : drive_proc
      logic          next_valid;
      path_item_type it;
      if (reset) begin
         req_valid <= 1'b0;
         req_path_byte <= 8'h00;
         req_end_of_path <= 1'b0;
         gap_left = 0;
      end else begin
         next_valid = req_valid;
         if (req_valid && req_ready) begin
            encode_byte(req_path_byte, req_end_of_path);
            next_valid = 1'b0;
         end
         if (!next_valid) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (path_bytes.size() > 0 &&
                         !(path_bytes[0].drain && names_due.size() > 0)) begin
               it = path_bytes.pop_front();
               req_path_byte <= it.ch;
               req_end_of_path <= it.fin;
               next_valid = 1'b1;
               if ($urandom_range(0, 59) == 0) tx_calm = !tx_calm;
               if (!tx_calm && $urandom_range(0, 3) == 0) gap_left = pick_gap();
            end
         end
         req_valid <= next_valid;
      end
   end

   // Monitor: stall at random, check each accepted short name.
   always @(posedge clock) begin : watch_proc
      short_name_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (names_due.size() == 0) begin
               report_mismatch("unexpected item, base_name", rsp_base_name, 64'd0);
            end else begin
               want = names_due.pop_front();
               if (rsp_base_name !== want.base)
                  report_mismatch("base_name", rsp_base_name, want.base);
               if (rsp_extension !== want.ext)
                  report_mismatch("extension", 64'(rsp_extension), 64'(want.ext));
               if (rsp_component_index !== want.idx)
                  report_mismatch("component_index", 64'(rsp_component_index),
                                  64'(want.idx));
               if (rsp_last_component !== want.last)
                  report_mismatch("last_component", 64'(rsp_last_component),
                                  64'(want.last));
               if (rsp_error_code !== want.err)
                  report_mismatch("error_code", 64'(rsp_error_code), 64'(want.err));
            end
         end
         if ($urandom_range(0, 79) == 0) rx_calm = !rx_calm;
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (!rx_calm && $urandom_range(0, 5) == 0) begin
            stall_left = pick_gap() - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      int  paths;
      bit  long_done;
      paths = 0;
      long_done = 1'b0;

      add_text("./../");
      queue_path(1'b0);
      add_text(".abcd/az`{@[");
      path_buf.push_back(8'h00);
      path_buf.push_back(8'hFF);
      add_text("Z");
      queue_path(1'b0);
      add_text("a../b.");
      queue_path(1'b0);

      while (path_bytes.size() < RANDOM_BYTES) begin
         if (!long_done && path_bytes.size() > 600) begin
            // index saturation: one path with more than 256 components
            repeat (258) begin
               path_buf.push_back(8'(8'h61 + $urandom_range(0, 25)));
               path_buf.push_back(SLASH_CHAR);
            end
            add_text("z");
            queue_path(1'b1);
            long_done = 1'b1;
         end
         add_random_path(paths % 6 == 0);
         paths++;
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (path_bytes.size() != 0 || req_valid) @(posedge clock);
      while (names_due.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && names_due.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// ----- fat_short_name_encoder_top.f -----
sv/fsne_pkg.sv
sv/fsne_absorb.sv
sv/fat_short_name_encoder_top.sv
sim/fat_short_name_encoder_top_tb.sv
